### hdl/price_level_order_book_top_assert.svh
// Assertion helpers for the order book top level.
`ifndef PRICE_LEVEL_ORDER_BOOK_TOP_ASSERT_SVH
`define PRICE_LEVEL_ORDER_BOOK_TOP_ASSERT_SVH
`ifndef SYNTH
`define PLOB_CHECK(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("plob: same-cycle check failed");
`define PLOB_CHECK_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("plob: next-cycle check failed");
`else
`define PLOB_CHECK(label, prop)
`define PLOB_CHECK_NEXT(label, ante, cons)
`endif
`endif

### hdl/plob_pkg.sv
package plob_pkg;

    localparam int unsigned DEF_PRICE_LEVELS = 256;
    localparam int unsigned DEF_ORDER_SLOTS  = 1024;
    localparam int unsigned DEF_VOLUME_BITS  = 32;

    localparam logic [1:0] ACT_ADD    = 2'd0;
    localparam logic [1:0] ACT_REMOVE = 2'd1;
    localparam logic [1:0] ACT_QUERY  = 2'd2;
    // unused code, handled as a query
    localparam logic [1:0] ACT_SPARE  = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_BUSY  = 2'd2;

    typedef struct packed {
        logic [1:0]  action;
        logic [9:0]  order_slot;
        logic [7:0]  price_tick;
        logic [31:0] quantity;
        logic        buy_side;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  top_bid;
        logic        bid_present;
        logic [7:0]  top_ask;
        logic        ask_present;
        logic [8:0]  mid_sum;
        logic [31:0] level_volume;
        logic        would_cross;
        logic [31:0] matched_volume;
    } t_out_item;

endpackage

### hdl/price_level_order_book_top.sv
// Price-level order book: bid and ask volume aggregated per tick.
// Input channel (i_in_valid / o_in_stall / i_in_data) takes one item a
// transfer: add, remove or query. Output channel (o_out_valid / i_out_stall /
// o_out_data) returns exactly one result per item, in order.
// After reset the block runs a clearing pass over the slot-valid and level
// memories; o_in_stall stays high then. Each item then takes one slot
// lookup, one level read-modify-write, and a scan of both level memories at
// one tick per cycle, set by the single read port and the shared saturating
// adder. The block takes no new item until the result of the last one has
// been loaded into the output register.
// The result sits in an output register; a stalled receiver holds it there
// and the block finishes its next item, then waits until the register frees.
module price_level_order_book_top import plob_pkg::*; #(
    parameter int unsigned PRICE_LEVELS = DEF_PRICE_LEVELS,
    parameter int unsigned ORDER_SLOTS  = DEF_ORDER_SLOTS,
    parameter int unsigned VOLUME_BITS  = DEF_VOLUME_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);
    localparam int unsigned LAW   = $clog2(PRICE_LEVELS);
    localparam int unsigned SAW   = $clog2(ORDER_SLOTS);
    localparam int unsigned CLR_N = (ORDER_SLOTS > PRICE_LEVELS) ? ORDER_SLOTS : PRICE_LEVELS;
    localparam int unsigned CW    = $clog2(CLR_N + 1);
    localparam int unsigned VB    = VOLUME_BITS;
    localparam int unsigned SDW   = LAW + VB + 1;
    localparam logic [LAW-1:0] LMAX = LAW'(PRICE_LEVELS - 1);
    localparam logic [VB-1:0]  VMAX = {VB{1'b1}};

    // sequencer states
    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_SLOT = 3'd2;
    localparam logic [2:0] S_LVL  = 3'd3;
    localparam logic [2:0] S_SCAN = 3'd4;
    localparam logic [2:0] S_TAIL = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0]     r_state;
    logic [CW-1:0]  r_clr;

    // latched item
    logic [1:0]     r_act;
    logic           r_slot_ok;
    logic [SAW-1:0] r_saddr;
    logic [LAW-1:0] r_p;
    logic [VB-1:0]  r_qty;
    logic           r_buy;
    logic [1:0]     r_status;

    // pending level update
    logic           r_lop;
    logic [LAW-1:0] r_laddr;
    logic           r_lside;
    logic           r_lsub;
    logic [VB-1:0]  r_lamt;

    // scan
    logic [LAW-1:0] r_idx;
    logic           r_dv;
    logic [LAW-1:0] r_didx;
    logic [LAW-1:0] r_bb;
    logic           r_bp;
    logic [LAW-1:0] r_ba;
    logic           r_ap;
    logic [VB-1:0]  r_lvl;
    logic [VB-1:0]  r_m;

    logic           r_ov;
    t_out_item      r_out;

    // memory ports
    logic           vld_we, vld_wd, vld_q;
    logic [SAW-1:0] vld_waddr;
    logic           sd_we;
    logic [SDW-1:0] sd_q;
    logic           bid_we, ask_we;
    logic [LAW-1:0] lvl_waddr, lvl_raddr;
    logic [VB-1:0]  lvl_wd, bid_q, ask_q;

    // decode of the incoming item
    logic           in_slot_ok;
    logic [LAW-1:0] in_p;
    logic [SAW-1:0] in_saddr;

    // slot stage
    logic           add_ok, rem_ok;
    logic [LAW-1:0] sd_p;
    logic [VB-1:0]  sd_qty;
    logic           sd_side;
    logic [LAW-1:0] op_addr;
    logic [VB-1:0]  lvl_old;

    // shared saturating adder
    logic [VB-1:0]  add_op;
    logic [VB:0]    add_sum;

    logic           accept;
    logic           load_out;
    logic [LAW:0]   mid_full;

    assign in_slot_ok = (32'(i_in_data.order_slot) < ORDER_SLOTS);
    assign in_p       = (32'(i_in_data.price_tick) > PRICE_LEVELS - 1) ? LMAX
                        : LAW'(i_in_data.price_tick);
    assign in_saddr   = SAW'(i_in_data.order_slot);

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && !o_in_stall;

    assign sd_side = sd_q[0];
    assign sd_qty  = sd_q[VB:1];
    assign sd_p    = sd_q[SDW-1:VB+1];

    assign add_ok  = (r_act == ACT_ADD) && r_slot_ok && !vld_q;
    assign rem_ok  = (r_act == ACT_REMOVE) && r_slot_ok && vld_q;
    assign op_addr = rem_ok ? sd_p : r_p;

    // clearing pass writes zero; otherwise commit or free the slot
    always_comb begin
        vld_we    = 1'b0;
        vld_wd    = 1'b0;
        vld_waddr = r_saddr;
        sd_we     = 1'b0;
        if (r_state == S_CLR) begin
            vld_we    = (32'(r_clr) < ORDER_SLOTS);
            vld_waddr = SAW'(r_clr);
        end else if (r_state == S_SLOT) begin
            vld_we = add_ok || rem_ok;
            vld_wd = add_ok;
            sd_we  = add_ok;
        end
    end

    assign lvl_old = r_lside ? bid_q : ask_q;

    always_comb begin
        bid_we    = 1'b0;
        ask_we    = 1'b0;
        lvl_waddr = r_laddr;
        lvl_wd    = r_lsub ? (lvl_old - r_lamt) : (lvl_old + r_lamt);
        if (r_state == S_CLR) begin
            bid_we    = (32'(r_clr) < PRICE_LEVELS);
            ask_we    = bid_we;
            lvl_waddr = LAW'(r_clr);
            lvl_wd    = '0;
        end else if (r_state == S_LVL) begin
            bid_we = r_lop && r_lside;
            ask_we = r_lop && !r_lside;
        end
    end

    assign lvl_raddr = (r_state == S_SCAN) ? r_idx
                       : ((r_state == S_SLOT) ? op_addr : r_laddr);

    plob_ram #(.WIDTH(1), .DEPTH(ORDER_SLOTS)) u_valid (
        .i_clk(i_clk), .i_we(vld_we), .i_waddr(vld_waddr), .i_wdata(vld_wd),
        .i_raddr(in_saddr), .o_rdata(vld_q)
    );

    plob_ram #(.WIDTH(SDW), .DEPTH(ORDER_SLOTS)) u_slot (
        .i_clk(i_clk), .i_we(sd_we), .i_waddr(r_saddr),
        .i_wdata({r_p, r_qty, r_buy}), .i_raddr(in_saddr), .o_rdata(sd_q)
    );

    plob_ram #(.WIDTH(VB), .DEPTH(PRICE_LEVELS)) u_bid (
        .i_clk(i_clk), .i_we(bid_we), .i_waddr(lvl_waddr), .i_wdata(lvl_wd),
        .i_raddr(lvl_raddr), .o_rdata(bid_q)
    );

    plob_ram #(.WIDTH(VB), .DEPTH(PRICE_LEVELS)) u_ask (
        .i_clk(i_clk), .i_we(ask_we), .i_waddr(lvl_waddr), .i_wdata(lvl_wd),
        .i_raddr(lvl_raddr), .o_rdata(ask_q)
    );

    // buy sums ask levels at or below the price, sell sums bid levels at or above
    always_comb begin
        if (r_buy) begin
            add_op = (r_didx <= r_p) ? ask_q : '0;
        end else begin
            add_op = (r_didx >= r_p) ? bid_q : '0;
        end
        add_sum = {1'b0, r_m} + {1'b0, add_op};
    end

    assign load_out = (r_state == S_DONE) && (!r_ov || !i_out_stall);
    assign mid_full = {1'b0, r_bb} + {1'b0, r_ba};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
            r_ov    <= 1'b0;
            r_dv    <= 1'b0;
        end else begin
            r_dv <= (r_state == S_SCAN);
            case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + CW'(1);
                    if (r_clr == CW'(CLR_N - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_SLOT;
                    end
                end
                S_SLOT: r_state <= S_LVL;
                S_LVL:  r_state <= S_SCAN;
                S_SCAN: begin
                    if (r_idx == LMAX) begin
                        r_state <= S_TAIL;
                    end
                end
                S_TAIL: r_state <= S_DONE;
                S_DONE: begin
                    if (load_out) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            if (load_out) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    // datapath: no reset needed
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_act     <= i_in_data.action;
            r_slot_ok <= in_slot_ok;
            r_saddr   <= in_saddr;
            r_p       <= in_p;
            r_qty     <= VB'(i_in_data.quantity);
            r_buy     <= i_in_data.buy_side;
        end

        if (r_state == S_SLOT) begin
            r_lop   <= add_ok || rem_ok;
            r_laddr <= op_addr;
            r_lside <= rem_ok ? sd_side : r_buy;
            r_lsub  <= rem_ok;
            r_lamt  <= rem_ok ? sd_qty : r_qty;
            if (r_act == ACT_ADD && !add_ok) begin
                r_status <= ST_BUSY;
            end else if (r_act == ACT_REMOVE && !rem_ok) begin
                r_status <= ST_EMPTY;
            end else begin
                r_status <= ST_OK;
            end
        end

        // start the scan from a clean slate
        if (r_state == S_LVL) begin
            r_idx <= '0;
            r_bb  <= '0;
            r_bp  <= 1'b0;
            r_ba  <= '0;
            r_ap  <= 1'b0;
            r_lvl <= '0;
            r_m   <= '0;
        end else if (r_state == S_SCAN) begin
            r_idx <= r_idx + LAW'(1);
        end

        r_didx <= r_idx;

        if (r_dv) begin
            if (bid_q != '0) begin
                r_bb <= r_didx;
                r_bp <= 1'b1;
            end
            if (!r_ap && ask_q != '0) begin
                r_ba <= r_didx;
                r_ap <= 1'b1;
            end
            if (r_didx == r_p) begin
                r_lvl <= r_buy ? bid_q : ask_q;
            end
            r_m <= add_sum[VB] ? VMAX : add_sum[VB-1:0];
        end

        if (load_out) begin
            r_out.status         <= r_status;
            r_out.top_bid        <= 8'(r_bb);
            r_out.bid_present    <= r_bp;
            r_out.top_ask        <= 8'(r_ba);
            r_out.ask_present    <= r_ap;
            r_out.mid_sum        <= (r_bp && r_ap) ? 9'(mid_full) : 9'd0;
            r_out.level_volume   <= 32'(r_lvl);
            r_out.would_cross    <= r_buy ? (r_ap && r_ba <= r_p) : (r_bp && r_bb >= r_p);
            r_out.matched_volume <= 32'(r_m);
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

`include "price_level_order_book_top_assert.svh"

    `PLOB_CHECK_NEXT(a_scan_ends, (r_state == S_SCAN && r_idx == LMAX), (r_state == S_TAIL))
    `PLOB_CHECK(a_load_from_done, ($rose(r_ov) |-> $past(r_state) == S_DONE))
    `PLOB_CHECK(a_no_out_in_clear, (r_state == S_CLR |-> !o_out_valid))

endmodule

### hdl/plob_ram.sv
module plob_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
